### hdl/quoted_printable_decoder_top_assert.svh
// ---------------------------------------------------------------------------
// Quoted-printable decoder assertion macros
// Clocked property wrappers shared by the decoder's assertions.
// ---------------------------------------------------------------------------
`ifndef QUOTED_PRINTABLE_DECODER_TOP_ASSERT_SVH
`define QUOTED_PRINTABLE_DECODER_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define QPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define QPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/qpd_pkg.sv
// ---------------------------------------------------------------------------
// Quoted-printable decoder package
// Payload types, escape state codes and the character mapping function.
// ---------------------------------------------------------------------------
package qpd_pkg;

  localparam logic [7:0] CharEquals  = 8'h3D;
  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharNine    = 8'h39;
  localparam logic [7:0] CharUpperF  = 8'h46;
  localparam logic [7:0] SubDigit    = 8'd48;
  localparam logic [7:0] SubUpper    = 8'd55;
  localparam logic [7:0] SubLower    = 8'd87;

  localparam logic [1:0] PhPlain = 2'd0;
  localparam logic [1:0] PhEqual = 2'd1;
  localparam logic [1:0] PhHigh  = 2'd2;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } qpd_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_message;
  } qpd_out_t;

  typedef struct packed {
    logic [1:0] phase;
    logic [3:0] high_nibble;
  } qpd_state_t;

  function automatic logic [7:0] qpd_map_char(input logic [7:0] v);
    logic [7:0] sub;
    if (v > CharNine) begin
      sub = (v > CharUpperF) ? SubLower : SubUpper;
    end else begin
      sub = SubDigit;
    end
    return v - sub;
  endfunction

endpackage

### hdl/qpd_stream_if.sv
// ---------------------------------------------------------------------------
// Quoted-printable decoder stream interface
// Valid/ready channel carrying one word of a configurable payload type.
// ---------------------------------------------------------------------------
interface qpd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/qpd_step.sv
// ---------------------------------------------------------------------------
// Quoted-printable decoder step
// Combinational next-state and result logic for one input word.
// ---------------------------------------------------------------------------
module qpd_step
  import qpd_pkg::*;
(
  input  logic       decode_mode_i,
  input  qpd_in_t    word_i,
  input  qpd_state_t state_i,
  output qpd_state_t state_o,
  output logic       emit_o,
  output qpd_out_t   result_o
);

  logic       have;
  logic [7:0] val;
  logic [7:0] mapped;
  qpd_state_t nxt;

  assign mapped = qpd_map_char(word_i.text_byte);

  always_comb begin
    have = 1'b0;
    val  = '0;
    nxt  = state_i;
    if (!decode_mode_i) begin
      nxt  = '0;
      have = 1'b1;
      val  = word_i.text_byte;
    end else begin
      unique case (state_i.phase)
        PhEqual: begin
          if (word_i.text_byte == CharNewline) begin
            nxt.phase = PhPlain;
          end else begin
            nxt.phase       = PhHigh;
            nxt.high_nibble = mapped[3:0];
          end
        end
        PhHigh: begin
          have = 1'b1;
          val  = {state_i.high_nibble, 4'b0000} | mapped;
          nxt  = '0;
        end
        default: begin
          if (word_i.text_byte == CharEquals) begin
            nxt.phase = PhEqual;
          end else begin
            nxt.phase = PhPlain;
            have      = 1'b1;
            val       = word_i.text_byte;
          end
        end
      endcase
    end

    if (word_i.text_byte == 8'h00) begin
      state_o  = '0;
      emit_o   = 1'b1;
      result_o = '{out_byte: 8'h00, byte_valid: 1'b0, end_of_message: 1'b1};
    end else if (word_i.end_of_text) begin
      state_o  = '0;
      emit_o   = 1'b1;
      result_o = '{out_byte: val, byte_valid: have, end_of_message: 1'b1};
    end else begin
      state_o  = nxt;
      emit_o   = have;
      result_o = '{out_byte: val, byte_valid: have, end_of_message: 1'b0};
    end
  end

endmodule

### hdl/quoted_printable_decoder_top.sv
// ---------------------------------------------------------------------------
// Quoted-printable decoder
// Decodes a byte stream in pass-through or quoted-printable mode.
// ---------------------------------------------------------------------------
// The text_i channel takes one word per byte of message text with its end
// flag. The result_o channel returns at most one word per input word: a
// decoded byte, which may carry the end marker, or an end marker without a
// byte. Soft line breaks and the first two characters of an escape return
// nothing. The cfg_i channel writes the decode mode and is always ready;
// the user must write it only while the block is idle, which the block
// itself does not enforce. An input word is held in an input register,
// decoded combinationally from it and written to the result register.
// One word is taken every cycle unless input stalls as described below;
// the escape state is updated as each word leaves the input register.
// Reset clears the mode to pass-through, the escape state and the valid
// flags of both registers. When the receiver stalls, the result register
// holds its word and the input register fills; input stalls only when both
// are full and the held input word would produce a result.
// ---------------------------------------------------------------------------
`include "quoted_printable_decoder_top_assert.svh"

module quoted_printable_decoder_top
  import qpd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  qpd_stream_if.sink   text_i,
  qpd_stream_if.source result_o,
  qpd_stream_if.sink   cfg_i
);

  logic       mode_q;
  logic       s1_valid_q;
  qpd_in_t    s1_data_q;
  qpd_state_t state_q;
  qpd_state_t state_d;
  logic       out_valid_q;
  qpd_out_t   out_data_q;
  logic       step_emit;
  qpd_out_t   step_result;
  logic       out_free;
  logic       s1_adv;

  qpd_step u_step (
    .decode_mode_i(mode_q),
    .word_i       (s1_data_q),
    .state_i      (state_q),
    .state_o      (state_d),
    .emit_o       (step_emit),
    .result_o     (step_result)
  );

  assign out_free     = !out_valid_q || result_o.ready;
  assign s1_adv       = s1_valid_q && (!step_emit || out_free);
  assign text_i.ready = !s1_valid_q || s1_adv;
  assign cfg_i.ready  = 1'b1;

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_i.valid) begin
      mode_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (text_i.ready) begin
      s1_valid_q <= text_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_i.valid && text_i.ready) begin
      s1_data_q <= text_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (s1_adv) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && step_emit) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && step_emit) begin
      out_data_q <= step_result;
    end
  end

  `QPD_ASSERT_NEXT(a_end_clears_state, s1_adv && s1_data_q.end_of_text, state_q == '0, "escape state not cleared at message end")
  `QPD_ASSERT_NEXT(a_pass_emits, s1_adv && !mode_q, out_valid_q, "pass-through word produced no result")
  `QPD_ASSERT_NEXT(a_s1_holds, s1_valid_q && !s1_adv, s1_valid_q && $stable(s1_data_q), "stalled input word was lost")
  `QPD_ASSERT_NOW(a_empty_is_end, out_valid_q && !out_data_q.byte_valid, out_data_q.end_of_message, "result without byte is not a message end")

endmodule

### bench/quoted_printable_decoder_top_test.sv
// ---------------------------------------------------------------------------
// Quoted-printable decoder testbench
// Sends message text through the decoder in pass-through and quoted-printable
// modes and checks every returned word against a local decoding of the text.
// Directed words cover field extremes, escapes, soft breaks and early ends;
// a long output stall follows, then random messages with random idling on
// both sides and a stretch without idling.
// ---------------------------------------------------------------------------
module quoted_printable_decoder_top_test;
  import qpd_pkg::*;

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic       ModePass  = 1'b0;
  localparam logic       ModeQp    = 1'b1;
  localparam int         IdleLimit = 2000;

  logic clk_i = 1'b0;
  logic rst_ni;

  qpd_stream_if #(.payload_t(qpd_in_t))  text_if ();
  qpd_stream_if #(.payload_t(qpd_out_t)) result_if ();
  qpd_stream_if #(.payload_t(logic))     cfg_if ();

  quoted_printable_decoder_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .text_i   (text_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  qpd_out_t   decoded_q[$];
  logic       qp_mode;
  logic [1:0] esc_phase;
  logic [3:0] esc_high;

  int idle_pct = 7;
  int stall_pct = 7;
  int hold_cycles = 0;
  int words_sent = 0;
  int messages_sent = 0;
  int results_checked = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [7:0] char_weight(input logic [7:0] c);
    if (c <= CharNine) begin
      return c - SubDigit;
    end else if (c <= CharUpperF) begin
      return c - SubUpper;
    end
    return c - SubLower;
  endfunction

  function automatic logic [7:0] random_hex_char();
    int k;
    k = $urandom_range(0, 21);
    if (k < 10) begin
      return 8'h30 + k[7:0];
    end else if (k < 16) begin
      return 8'h41 + k[7:0] - 8'd10;
    end
    return 8'h61 + k[7:0] - 8'd16;
  endfunction

  function automatic logic [7:0] random_plain_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(1, 255));
    end while (c == CharEquals);
    return c;
  endfunction

  task automatic push_decoded(input logic [7:0] val, input logic have, input logic last);
    qpd_out_t res;
    res.out_byte       = have ? val : 8'h00;
    res.byte_valid     = have;
    res.end_of_message = last;
    decoded_q.push_back(res);
  endtask

  task automatic decode_text_word(input logic [7:0] b, input logic eot);
    logic       have;
    logic [7:0] val;
    logic [7:0] weight;
    have = 1'b0;
    val  = 8'h00;
    if (b == CharNul) begin
      esc_phase = PhPlain;
      esc_high  = 4'h0;
      messages_sent++;
      push_decoded(8'h00, 1'b0, 1'b1);
      return;
    end
    if (qp_mode == ModePass) begin
      esc_phase = PhPlain;
      esc_high  = 4'h0;
      have      = 1'b1;
      val       = b;
    end else begin
      case (esc_phase)
        PhEqual: begin
          if (b == CharNewline) begin
            esc_phase = PhPlain;
          end else begin
            weight    = char_weight(b);
            esc_high  = weight[3:0];
            esc_phase = PhHigh;
          end
        end
        PhHigh: begin
          val       = {esc_high, 4'h0} | char_weight(b);
          have      = 1'b1;
          esc_phase = PhPlain;
          esc_high  = 4'h0;
        end
        default: begin
          if (b == CharEquals) begin
            esc_phase = PhEqual;
          end else begin
            esc_phase = PhPlain;
            have      = 1'b1;
            val       = b;
          end
        end
      endcase
    end
    if (eot) begin
      esc_phase = PhPlain;
      esc_high  = 4'h0;
      messages_sent++;
      push_decoded(val, have, 1'b1);
    end else if (have) begin
      push_decoded(val, 1'b1, 1'b0);
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH at result %0d: %s", results_checked, msg);
  endtask

  task automatic send_word(input logic [7:0] b, input logic eot = 1'b0);
    qpd_in_t w;
    w.text_byte   = b;
    w.end_of_text = eot;
    @(negedge clk_i);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      text_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    text_if.valid <= 1'b1;
    text_if.data  <= w;
    @(posedge clk_i);
    while (!text_if.ready) begin
      @(posedge clk_i);
    end
    words_sent++;
    decode_text_word(b, eot);
  endtask

  task automatic drain_decoder(input int extra);
    @(negedge clk_i);
    text_if.valid <= 1'b0;
    while (decoded_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic write_mode(input logic mode);
    drain_decoder(4);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= mode;
    @(posedge clk_i);
    while (!cfg_if.ready) begin
      @(posedge clk_i);
    end
    qp_mode = mode;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_random_message();
    int tokens;
    int kind;
    tokens = $urandom_range(1, 12);
    repeat (tokens) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        send_word(random_plain_char());
      end else if (kind < 75) begin
        send_word(CharEquals);
        send_word(random_hex_char());
        send_word(random_hex_char());
      end else if (kind < 85) begin
        send_word(CharEquals);
        send_word(CharNewline);
      end else if (kind < 93) begin
        send_word(8'($urandom_range(1, 255)));
      end else if (kind < 96) begin
        send_word(CharNul);
      end else begin
        send_word(CharEquals);
        send_word(8'($urandom_range(1, 255)));
      end
    end
    case ($urandom_range(0, 5))
      0: send_word(CharNul);
      1: send_word(CharEquals, 1'b1);
      2: send_word(8'($urandom_range(0, 255)), 1'b1);
      default: send_word(random_plain_char(), 1'b1);
    endcase
  endtask

  task automatic test_passthrough_directed();
    write_mode(ModePass);
    send_word(8'h01);
    send_word(8'h80);
    send_word(CharEquals);
    send_word(CharNewline);
    send_word(8'hFF, 1'b1);
    send_word(8'h7F);
    send_word(CharNul);
  endtask

  task automatic test_qp_directed();
    write_mode(ModeQp);
    send_word(CharEquals);
    send_word(8'h34);
    send_word(8'h31);
    send_word(CharEquals);
    send_word(CharNewline);
    send_word(CharEquals);
    send_word(8'h66);
    send_word(8'h66);
    send_word(CharEquals);
    send_word(8'hFF);
    send_word(8'h80);
    send_word(8'h61);
    send_word(CharEquals, 1'b1);
    send_word(CharEquals);
    send_word(8'h34);
    send_word(CharNul);
    send_word(CharEquals);
    send_word(CharNewline, 1'b1);
  endtask

  task automatic test_pending_escape_passthrough();
    send_word(CharEquals);
    write_mode(ModePass);
    send_word(8'h51);
  endtask

  task automatic test_output_stall();
    int i;
    idle_pct = 0;
    @(negedge clk_i);
    text_if.valid <= 1'b0;
    hold_cycles = 48;
    for (i = 0; i < 24; i++) begin
      send_word(8'($urandom_range(1, 255)), i == 23);
    end
    idle_pct = 7;
  endtask

  task automatic test_random_text(input logic mode, input int target, input bit no_idle);
    int start;
    write_mode(mode);
    if (no_idle) begin
      idle_pct  = 0;
      stall_pct = 0;
    end
    start = words_sent;
    while (words_sent - start < target) begin
      send_random_message();
    end
    idle_pct  = 7;
    stall_pct = 7;
  endtask

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      result_if.ready <= 1'b0;
      hold_cycles--;
    end else begin
      result_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    qpd_out_t got;
    qpd_out_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      got = result_if.data;
      if (decoded_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h/%b/%b", got.out_byte,
                                  got.byte_valid, got.end_of_message));
      end else begin
        want = decoded_q.pop_front();
        if (got.out_byte !== want.out_byte) begin
          report_mismatch($sformatf("out_byte %h, expected %h", got.out_byte,
                                    want.out_byte));
        end
        if (got.byte_valid !== want.byte_valid) begin
          report_mismatch($sformatf("byte_valid %b, expected %b", got.byte_valid,
                                    want.byte_valid));
        end
        if (got.end_of_message !== want.end_of_message) begin
          report_mismatch($sformatf("end_of_message %b, expected %b",
                                    got.end_of_message, want.end_of_message));
        end
      end
      results_checked++;
    end
  end

  always @(posedge clk_i) begin
    if ((text_if.valid && text_if.ready) || (result_if.valid && result_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IdleLimit) begin
      $display("Timeout after %0d cycles without progress.", IdleLimit);
      $display("quoted_printable_decoder_top regression: fail");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    text_if.valid   = 1'b0;
    text_if.data    = '0;
    result_if.ready = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.data     = 1'b0;
    qp_mode         = ModePass;
    esc_phase       = PhPlain;
    esc_high        = 4'h0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_passthrough_directed();
    test_qp_directed();
    test_pending_escape_passthrough();
    test_output_stall();
    test_random_text(ModeQp, 250, 1'b0);
    test_random_text(ModePass, 100, 1'b0);
    test_random_text(ModeQp, 120, 1'b1);

    drain_decoder(8);
    $display("Sent %0d words in %0d messages and checked %0d result words.",
             words_sent, messages_sent, results_checked);
    $display("Both modes, escapes, soft breaks, early ends and a long output stall ran.");
    if (mismatches == 0) begin
      $display("quoted_printable_decoder_top regression: pass");
    end else begin
      $display("quoted_printable_decoder_top regression: fail");
    end
    $finish;
  end

endmodule
